>>> sv/lvr_pkg.sv
package lvr_pkg;

  localparam int COLOR_W = 2;
  localparam int TOTAL_W = 11;

  // order in which the up, left, right and down edges around a vertex are visited
  typedef enum logic [1:0] {
    EDGE_UP = 2'd0,
    EDGE_LF = 2'd1,
    EDGE_RT = 2'd2,
    EDGE_DN = 2'd3
  } edge_sel_t;

  // reduce a small index below m by repeated compare and subtract
  function automatic logic [3:0] wrap_u4(input logic [3:0] v, input int unsigned m);
    logic [3:0] t;
    t = v;
    for (int i = 0; i < 8; i++) begin
      if (32'(t) >= m) begin
        t = t - 4'(m);
      end
    end
    return t;
  endfunction

  // (old + step) reduced below m, for m from 2 to 4
  function automatic logic [COLOR_W-1:0] color_add(input logic [COLOR_W-1:0] c,
                                                   input logic [COLOR_W-1:0] s,
                                                   input int unsigned m);
    logic [COLOR_W:0] t;
    t = {1'b0, c} + {1'b0, s};
    for (int i = 0; i < 3; i++) begin
      if (32'(t) >= m) begin
        t = t - (COLOR_W + 1)'(m);
      end
    end
    return COLOR_W'(t);
  endfunction

endpackage

>>> sv/lvr_addr_gen.sv
module lvr_addr_gen
  import lvr_pkg::*;
#(
  parameter int HEIGHT = 16,
  parameter int WIDTH  = 16,
  parameter int ER_W   = 5,
  parameter int COL_W  = 4,
  parameter int ADDR_W = 9
) (
  input  edge_sel_t         sel,
  input  logic [ER_W-1:0]   erow,
  input  logic [COL_W-1:0]  col,
  output logic [ADDR_W-1:0] addr
);

  logic [ER_W-1:0]  erow_sel;
  logic [COL_W-1:0] col_sel;

  always_comb begin
    erow_sel = erow;
    col_sel  = col;
    case (sel)
      EDGE_UP: begin
        erow_sel = (erow == '0) ? ER_W'(2 * HEIGHT - 1) : erow - ER_W'(1);
      end
      EDGE_LF: begin
        col_sel = (col == '0) ? COL_W'(WIDTH - 1) : col - COL_W'(1);
      end
      EDGE_RT: begin
        erow_sel = erow;
      end
      EDGE_DN: begin
        // erow is even, so erow + 1 stays inside the lattice
        erow_sel = erow + ER_W'(1);
      end
      default: begin
        erow_sel = erow;
      end
    endcase
  end

  assign addr = ADDR_W'(erow_sel) * ADDR_W'(WIDTH) + ADDR_W'(col_sel);

endmodule

>>> sv/lvr_edge_mem.sv
module lvr_edge_mem
  import lvr_pkg::*;
#(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [COLOR_W-1:0] wdata,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/lattice_vertex_recolor_update.sv
// Vertex recolor update on a toroidal lattice of 2*HEIGHT x WIDTH colored
// edges held in one single-port memory. After reset the block sweeps the
// memory to color 0 and holds in_stall high meanwhile. Each request then
// reads the up, left, right and down edges of the vertex one per cycle
// through the shared address unit, and rewrites all of them, again one
// per cycle, when they match. The single memory port orders the work:
// the reads, then the writes on a flip, then the load of the output
// register, which waits while an earlier result is still held there under
// out_stall. The result waits in that register, and the next request is
// taken at the edge after it has been loaded, so a request is not accepted
// before the last one is through.
module lattice_vertex_recolor_update
  import lvr_pkg::*;
#(
  parameter int HEIGHT = 16,
  parameter int WIDTH  = 16,
  parameter int COLORS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_vertex_row,
  input  logic [3:0]         in_vertex_col,
  input  logic [1:0]         in_color_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_flipped,
  output logic [1:0]         out_prior_color,
  output logic [1:0]         out_next_color,
  output logic [TOTAL_W-1:0] out_color_total
);

  localparam int EDGE_COUNT = 2 * HEIGHT * WIDTH;
  localparam int ER_W       = $clog2(2 * HEIGHT);
  localparam int COL_W      = $clog2(WIDTH);
  localparam int ADDR_W     = $clog2(EDGE_COUNT);
  localparam int SUM_FULL   = $clog2(EDGE_COUNT * (COLORS - 1) + 1);
  localparam int SUM_W      = (SUM_FULL > TOTAL_W) ? SUM_FULL : TOTAL_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [2:0]          ph_r, ph_nxt;
  logic [ER_W-1:0]     erow_r, erow_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [COLOR_W-1:0]  step_r, step_nxt;
  logic [COLOR_W-1:0]  old_r, old_nxt;
  logic [COLOR_W-1:0]  nc_r, nc_nxt;
  logic                match_r, match_nxt;
  logic                flip_r, flip_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_flipped_r, out_flipped_nxt;
  logic [COLOR_W-1:0]  out_old_r, out_old_nxt;
  logic [COLOR_W-1:0]  out_new_r, out_new_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic                in_acc;
  logic [3:0]          row_w;
  logic [3:0]          col_w;
  edge_sel_t           sel;
  logic [ADDR_W-1:0]   gen_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [COLOR_W-1:0]  mem_wdata;
  logic [COLOR_W-1:0]  mem_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign row_w    = wrap_u4(in_vertex_row, HEIGHT);
  assign col_w    = wrap_u4(in_vertex_col, WIDTH);
  assign sel      = edge_sel_t'(ph_r[1:0]);

  lvr_addr_gen #(
    .HEIGHT (HEIGHT),
    .WIDTH  (WIDTH),
    .ER_W   (ER_W),
    .COL_W  (COL_W),
    .ADDR_W (ADDR_W)
  ) u_addr (
    .sel  (sel),
    .erow (erow_r),
    .col  (col_r),
    .addr (gen_addr)
  );

  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_r == S_WRITE);
      mem_addr  = gen_addr;
      mem_wdata = nc_r;
    end
  end

  lvr_edge_mem #(
    .DEPTH  (EDGE_COUNT),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    ph_nxt          = ph_r;
    erow_nxt        = erow_r;
    col_nxt         = col_r;
    step_nxt        = step_r;
    old_nxt         = old_r;
    nc_nxt          = nc_r;
    match_nxt       = match_r;
    flip_nxt        = flip_r;
    sum_nxt         = sum_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_flipped_nxt = out_flipped_r;
    out_old_nxt     = out_old_r;
    out_new_nxt     = out_new_r;
    out_total_nxt   = out_total_r;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(EDGE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          erow_nxt  = ER_W'({row_w, 1'b0});
          col_nxt   = COL_W'(col_w);
          step_nxt  = in_color_step;
          ph_nxt    = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // read data is registered, so it arrives in the cycle after its address
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd1) begin
          old_nxt   = mem_rdata;
          match_nxt = 1'b1;
        end else if (ph_r != 3'd0) begin
          match_nxt = match_r && (mem_rdata == old_r);
        end
        if (ph_r == 3'd4) begin
          ph_nxt = '0;
          nc_nxt = color_add(old_r, step_r, COLORS);
          if (match_r && (mem_rdata == old_r)) begin
            flip_nxt  = 1'b1;
            state_nxt = S_WRITE;
          end else begin
            flip_nxt  = 1'b0;
            nc_nxt    = old_r;
            state_nxt = S_DONE;
          end
        end
      end
      S_WRITE: begin
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd3) begin
          sum_nxt   = sum_r - SUM_W'({old_r, 2'b00}) + SUM_W'({nc_r, 2'b00});
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_flipped_nxt = flip_r;
          out_old_nxt     = old_r;
          out_new_nxt     = nc_r;
          out_total_nxt   = sum_r[TOTAL_W-1:0];
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ph_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ph_r        <= ph_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    erow_r        <= erow_nxt;
    col_r         <= col_nxt;
    step_r        <= step_nxt;
    old_r         <= old_nxt;
    nc_r          <= nc_nxt;
    match_r       <= match_nxt;
    flip_r        <= flip_nxt;
    out_flipped_r <= out_flipped_nxt;
    out_old_r     <= out_old_nxt;
    out_new_r     <= out_new_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_flipped     = out_flipped_r;
  assign out_prior_color = out_old_r;
  assign out_next_color  = out_new_r;
  assign out_color_total = out_total_r;

endmodule
